// ----- rtl/core/iee_pkg.sv -----
// shared types, codes and helper functions of the infix expression evaluator
package iee_pkg;

  // operator stack codes
  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4
  } op_code_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_FULL      = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_SAT       = 3'd4
  } status_t;

  // character classes
  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_LPAREN,
    CC_RPAREN,
    CC_OPER,
    CC_OTHER
  } char_class_t;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHAR,
    S_CLASS,
    S_RP_RD,
    S_RP_TEST,
    S_OP_RD,
    S_OP_TEST,
    S_END,
    S_FIN_RD,
    S_FIN_TEST,
    S_FIN_VRD,
    S_RED_RB,
    S_RED_RA,
    S_RED_EX,
    S_RED_ALU,
    S_OUT
  } ctrl_state_t;

  // arithmetic unit phases
  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV,
    A_FIN
  } alu_phase_t;

  // character codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // multiplier operand slice per cycle
  localparam int MUL_CHUNK = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic latch_in;
    logic digit;
    logic flush;
    logic push_lparen;
    logic push_oper;
    logic pop_op;
    logic red_pop;
    logic sel_second;
    logic latch_b;
    logic alu_start;
    logic red_wb;
    logic note_mal;
    logic load_out;
    logic clear;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    char_class_t cls;
    logic        aborted;
    logic        nip;
    logic        last;
    logic        ocnt_zero;
    logic        top_lparen;
    logic        top_rank_ge;
    logic        vcnt_lt2;
    logic        vcnt_one;
    logic        alu_done;
    logic        out_busy;
  } dp_status_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = CC_DIGIT;
    end else begin
      case (c)
        CH_LPAREN: r = CC_LPAREN;
        CH_RPAREN: r = CC_RPAREN;
        CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: r = CC_OPER;
        default: r = CC_OTHER;
      endcase
    end
    return r;
  endfunction

  function automatic op_code_t op_of(input logic [7:0] c);
    op_code_t r;
    case (c)
      CH_PLUS:  r = OP_ADD;
      CH_MINUS: r = OP_SUB;
      CH_STAR:  r = OP_MUL;
      CH_SLASH: r = OP_DIV;
      default:  r = OP_LPAREN;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rank(input op_code_t op);
    logic [1:0] r;
    case (op)
      OP_ADD, OP_SUB: r = 2'd1;
      OP_MUL, OP_DIV: r = 2'd2;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  // saturation never overrides an error; the first error sticks
  function automatic status_t note(input status_t cur, input status_t st);
    status_t r;
    r = cur;
    if (st == ST_SAT) begin
      if (cur == ST_OK) r = ST_SAT;
    end else if (st != ST_OK && (cur == ST_OK || cur == ST_SAT)) begin
      r = st;
    end
    return r;
  endfunction

  function automatic logic is_abort(input status_t st);
    return (st != ST_OK) && (st != ST_SAT);
  endfunction

endpackage

// ----- rtl/core/iee_ctrl.sv -----
// controller state machine sequencing character handling and reductions
module iee_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  iee_pkg::dp_status_t  st,
  output iee_pkg::ctrl_cmd_t   cmd,
  output logic                 in_ready
);

  iee_pkg::ctrl_state_t state_r, state_nxt;
  iee_pkg::ctrl_state_t ret_r, ret_nxt;
  logic red_bad;
  logic op_reduce;

  assign red_bad   = st.top_lparen || st.vcnt_lt2;
  assign op_reduce = !st.ocnt_zero && !st.top_lparen && st.top_rank_ge;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iee_pkg::S_IDLE;
      ret_r   <= iee_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      iee_pkg::S_IDLE: begin
        if (in_fire) state_nxt = iee_pkg::S_CHAR;
      end
      iee_pkg::S_CHAR: begin
        if (st.aborted || st.cls == iee_pkg::CC_DIGIT) state_nxt = iee_pkg::S_END;
        else state_nxt = iee_pkg::S_CLASS;
      end
      iee_pkg::S_CLASS: begin
        if (st.aborted) begin
          state_nxt = iee_pkg::S_END;
        end else begin
          case (st.cls)
            iee_pkg::CC_RPAREN: state_nxt = iee_pkg::S_RP_RD;
            iee_pkg::CC_OPER:   state_nxt = iee_pkg::S_OP_RD;
            default:            state_nxt = iee_pkg::S_END;
          endcase
        end
      end
      iee_pkg::S_RP_RD: state_nxt = iee_pkg::S_RP_TEST;
      iee_pkg::S_RP_TEST: begin
        if (st.aborted || st.ocnt_zero || st.top_lparen) begin
          state_nxt = iee_pkg::S_END;
        end else begin
          ret_nxt   = iee_pkg::S_RP_RD;
          state_nxt = red_bad ? iee_pkg::S_RP_RD : iee_pkg::S_RED_RB;
        end
      end
      iee_pkg::S_OP_RD: state_nxt = iee_pkg::S_OP_TEST;
      iee_pkg::S_OP_TEST: begin
        if (!st.aborted && op_reduce) begin
          ret_nxt   = iee_pkg::S_OP_RD;
          state_nxt = red_bad ? iee_pkg::S_OP_RD : iee_pkg::S_RED_RB;
        end else begin
          state_nxt = iee_pkg::S_END;
        end
      end
      iee_pkg::S_END: begin
        if (!st.last) state_nxt = iee_pkg::S_IDLE;
        else if (st.aborted) state_nxt = iee_pkg::S_OUT;
        else state_nxt = iee_pkg::S_FIN_RD;
      end
      iee_pkg::S_FIN_RD: state_nxt = iee_pkg::S_FIN_TEST;
      iee_pkg::S_FIN_TEST: begin
        if (st.aborted) begin
          state_nxt = iee_pkg::S_OUT;
        end else if (!st.ocnt_zero) begin
          ret_nxt   = iee_pkg::S_FIN_RD;
          state_nxt = red_bad ? iee_pkg::S_FIN_RD : iee_pkg::S_RED_RB;
        end else begin
          state_nxt = iee_pkg::S_FIN_VRD;
        end
      end
      iee_pkg::S_FIN_VRD: state_nxt = iee_pkg::S_OUT;
      iee_pkg::S_RED_RB:  state_nxt = iee_pkg::S_RED_RA;
      iee_pkg::S_RED_RA:  state_nxt = iee_pkg::S_RED_EX;
      iee_pkg::S_RED_EX:  state_nxt = iee_pkg::S_RED_ALU;
      iee_pkg::S_RED_ALU: begin
        if (st.alu_done) state_nxt = ret_r;
      end
      iee_pkg::S_OUT: begin
        if (!st.out_busy) state_nxt = iee_pkg::S_IDLE;
      end
      default: state_nxt = iee_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      iee_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_fire;
      end
      iee_pkg::S_CHAR: begin
        if (!st.aborted) begin
          cmd.digit = (st.cls == iee_pkg::CC_DIGIT);
          cmd.flush = (st.cls != iee_pkg::CC_DIGIT) && st.nip;
        end
      end
      iee_pkg::S_CLASS: begin
        cmd.push_lparen = !st.aborted && (st.cls == iee_pkg::CC_LPAREN);
      end
      iee_pkg::S_RP_TEST: begin
        if (!st.aborted) begin
          if (st.ocnt_zero) begin
            cmd.note_mal = 1'b1;
          end else if (st.top_lparen) begin
            cmd.pop_op = 1'b1;
          end else begin
            cmd.red_pop  = 1'b1;
            cmd.note_mal = red_bad;
          end
        end
      end
      iee_pkg::S_OP_TEST: begin
        if (!st.aborted) begin
          if (op_reduce) begin
            cmd.red_pop  = 1'b1;
            cmd.note_mal = red_bad;
          end else begin
            cmd.push_oper = 1'b1;
          end
        end
      end
      iee_pkg::S_END: begin
        cmd.flush = st.last && !st.aborted && st.nip;
      end
      iee_pkg::S_FIN_TEST: begin
        if (!st.aborted) begin
          if (!st.ocnt_zero) begin
            cmd.red_pop  = 1'b1;
            cmd.note_mal = red_bad;
          end else begin
            cmd.note_mal = !st.vcnt_one;
          end
        end
      end
      iee_pkg::S_RED_RA: begin
        cmd.latch_b    = 1'b1;
        cmd.sel_second = 1'b1;
      end
      iee_pkg::S_RED_EX: begin
        cmd.alu_start = 1'b1;
      end
      iee_pkg::S_RED_ALU: begin
        cmd.red_wb = st.alu_done;
      end
      iee_pkg::S_OUT: begin
        cmd.load_out = !st.out_busy;
        cmd.clear    = !st.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/iee_alu.sv -----
// saturating fixed point arithmetic unit: add/sub done in the cycle after start, sliced multiply, radix-2 divide
module iee_alu #(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  iee_pkg::op_code_t             op,
  input  logic signed [VALUE_WIDTH-1:0] a,
  input  logic signed [VALUE_WIDTH-1:0] b,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] result,
  output logic                          sat,
  output logic                          divz
);

  localparam int W    = VALUE_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int MC   = iee_pkg::MUL_CHUNK;
  localparam int NCH  = (W + MC - 1) / MC;
  localparam int BW   = NCH * MC;
  localparam int QW   = W + ((BW > F) ? BW : F);
  localparam int NW   = W + F;
  localparam int CNTW = $clog2(NW + 1);
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

  iee_pkg::alu_phase_t phase_r, phase_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic            neg_r, neg_nxt;
  logic            is_mul_r, is_mul_nxt;
  logic [W-1:0]    amag_r, amag_nxt;
  logic [BW-1:0]   bsh_r, bsh_nxt;
  logic [W-1:0]    d_r, d_nxt;
  logic [NW-1:0]   num_r, num_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]   acc_r, acc_nxt;
  logic [W-1:0]    res_r, res_nxt;
  logic            sat_r, sat_nxt;
  logic            divz_r, divz_nxt;

  logic [W:0]       sum;
  logic [W-1:0]     amag_in, bmag_in;
  logic [W+MC-1:0]  prod;
  logic [W:0]       rsh;
  logic             ge;
  logic [QW-1:0]    mq, lim;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  assign amag_in = mag(a);
  assign bmag_in = mag(b);
  assign prod    = amag_r * bsh_r[BW-1 -: MC];
  assign rsh     = {rem_r, num_r[NW-1]};
  assign ge      = rsh >= {1'b0, d_r};
  assign mq      = is_mul_r ? (acc_r >> F) : acc_r;
  assign lim     = neg_r ? (QW'(MAX_POS) + QW'(1)) : QW'(MAX_POS);

  // sequencing and arithmetic steps
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    neg_nxt    = neg_r;
    is_mul_nxt = is_mul_r;
    amag_nxt   = amag_r;
    bsh_nxt    = bsh_r;
    d_nxt      = d_r;
    num_nxt    = num_r;
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    res_nxt    = res_r;
    sat_nxt    = sat_r;
    divz_nxt   = divz_r;
    sum        = '0;
    case (phase_r)
      iee_pkg::A_IDLE: begin
        if (start) begin
          neg_nxt  = a[W-1] ^ b[W-1];
          sat_nxt  = 1'b0;
          divz_nxt = 1'b0;
          case (op)
            iee_pkg::OP_ADD, iee_pkg::OP_SUB: begin
              if (op == iee_pkg::OP_ADD) sum = {a[W-1], a} + {b[W-1], b};
              else sum = {a[W-1], a} - {b[W-1], b};
              if (sum[W] != sum[W-1]) begin
                sat_nxt = 1'b1;
                res_nxt = sum[W] ? MIN_NEG : MAX_POS;
              end else begin
                res_nxt = sum[W-1:0];
              end
              done_nxt = 1'b1;
            end
            iee_pkg::OP_MUL: begin
              amag_nxt   = amag_in;
              bsh_nxt    = BW'(bmag_in);
              acc_nxt    = '0;
              cnt_nxt    = CNTW'(NCH);
              is_mul_nxt = 1'b1;
              phase_nxt  = iee_pkg::A_MUL;
            end
            iee_pkg::OP_DIV: begin
              if (bmag_in == '0) begin
                res_nxt  = '0;
                divz_nxt = 1'b1;
                done_nxt = 1'b1;
              end else begin
                d_nxt      = bmag_in;
                num_nxt    = NW'(amag_in) << F;
                rem_nxt    = '0;
                acc_nxt    = '0;
                cnt_nxt    = CNTW'(NW);
                is_mul_nxt = 1'b0;
                phase_nxt  = iee_pkg::A_DIV;
              end
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      // one operand slice per cycle, most significant first
      iee_pkg::A_MUL: begin
        acc_nxt = (acc_r << MC) + QW'(prod);
        bsh_nxt = bsh_r << MC;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) phase_nxt = iee_pkg::A_FIN;
      end
      // one quotient bit per cycle
      iee_pkg::A_DIV: begin
        rem_nxt = ge ? W'(rsh - {1'b0, d_r}) : rsh[W-1:0];
        acc_nxt = {acc_r[QW-2:0], ge};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) phase_nxt = iee_pkg::A_FIN;
      end
      // apply sign and saturate
      iee_pkg::A_FIN: begin
        if (mq > lim) begin
          sat_nxt = 1'b1;
          res_nxt = neg_r ? MIN_NEG : MAX_POS;
        end else begin
          res_nxt = neg_r ? (~mq[W-1:0] + W'(1)) : mq[W-1:0];
        end
        done_nxt  = 1'b1;
        phase_nxt = iee_pkg::A_IDLE;
      end
      default: phase_nxt = iee_pkg::A_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= iee_pkg::A_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    is_mul_r <= is_mul_nxt;
    amag_r   <= amag_nxt;
    bsh_r    <= bsh_nxt;
    d_r      <= d_nxt;
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
    sat_r    <= sat_nxt;
    divz_r   <= divz_nxt;
  end

  assign done   = done_r;
  assign result = res_r;
  assign sat    = sat_r;
  assign divz   = divz_r;

endmodule

// ----- rtl/core/iee_datapath.sv -----
// datapath: value and operator stacks, number assembly, status and output register
module iee_datapath #(
  parameter int STACK_DEPTH   = 64,
  parameter int FRACTION_BITS = 16,
  parameter int VALUE_WIDTH   = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iee_pkg::ctrl_cmd_t            cmd,
  output iee_pkg::dp_status_t           st,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_end_of_expr,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic [2:0]                    out_status
);

  localparam int W  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int D  = STACK_DEPTH;
  localparam int AW = $clog2(D);
  localparam int CW = $clog2(D + 1);
  localparam int EW = W + F + 5;
  localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  logic [W-1:0]      vmem [D];
  iee_pkg::op_code_t opmem [D];

  logic [7:0]        char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [CW-1:0]     vcnt_r, vcnt_nxt;
  logic [CW-1:0]     ocnt_r, ocnt_nxt;
  logic [W-1:0]      pend_r, pend_nxt;
  logic              nip_r, nip_nxt;
  iee_pkg::status_t  sticky_r, sticky_nxt;
  logic [W-1:0]      b_r, b_nxt;
  iee_pkg::op_code_t opcur_r, opcur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [W-1:0]      out_value_r, out_value_nxt;
  iee_pkg::status_t  out_status_r, out_status_nxt;
  logic [W-1:0]      vrd_r;
  iee_pkg::op_code_t ord_r;

  logic [CW-1:0]     vtop_m1, vtop_m2, otop_m1;
  logic              vfull, ofull, aborted;
  logic [7:0]        dig8;
  logic [EW-1:0]     pend_e, num10;
  logic              dig_sat;
  logic              push_op;
  iee_pkg::op_code_t push_code;
  iee_pkg::status_t  note_code;
  logic [AW-1:0]     vaddr, v_waddr;
  logic              v_we, o_we;
  logic [W-1:0]      v_wdata;
  logic              alu_done, alu_sat, alu_divz;
  logic [W-1:0]      alu_res;

  assign vtop_m1 = vcnt_r - CW'(1);
  assign vtop_m2 = vcnt_r - CW'(2);
  assign otop_m1 = ocnt_r - CW'(1);
  assign vfull   = vcnt_r >= CW'(D);
  assign ofull   = ocnt_r >= CW'(D);
  assign aborted = iee_pkg::is_abort(sticky_r);

  // decimal digit accumulation with saturation
  assign dig8    = char_r - iee_pkg::CH_ZERO;
  assign pend_e  = EW'(pend_r);
  assign num10   = (pend_e << 3) + (pend_e << 1) + (EW'(dig8[3:0]) << F);
  assign dig_sat = num10 > EW'(MAX_POS);

  assign push_op   = cmd.push_lparen || cmd.push_oper;
  assign push_code = cmd.push_lparen ? iee_pkg::OP_LPAREN : iee_pkg::op_of(char_r);

  // stack port control
  assign vaddr   = cmd.sel_second ? vtop_m2[AW-1:0] : vtop_m1[AW-1:0];
  assign v_we    = (cmd.flush && !vfull) || cmd.red_wb;
  assign v_waddr = cmd.red_wb ? vtop_m2[AW-1:0] : vcnt_r[AW-1:0];
  assign v_wdata = cmd.red_wb ? alu_res : pend_r;
  assign o_we    = push_op && !ofull;

  // status event of this cycle
  always_comb begin
    note_code = iee_pkg::ST_OK;
    if (cmd.digit && dig_sat) note_code = iee_pkg::ST_SAT;
    else if (cmd.flush && vfull) note_code = iee_pkg::ST_FULL;
    else if (push_op && ofull) note_code = iee_pkg::ST_FULL;
    else if (cmd.note_mal) note_code = iee_pkg::ST_MALFORMED;
    else if (cmd.red_wb && alu_divz) note_code = iee_pkg::ST_DIVZERO;
    else if (cmd.red_wb && alu_sat) note_code = iee_pkg::ST_SAT;
  end

  // next register values
  always_comb begin
    char_nxt       = char_r;
    last_nxt       = last_r;
    vcnt_nxt       = vcnt_r;
    ocnt_nxt       = ocnt_r;
    pend_nxt       = pend_r;
    nip_nxt        = nip_r;
    b_nxt          = b_r;
    opcur_nxt      = opcur_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    sticky_nxt     = iee_pkg::note(sticky_r, note_code);
    out_valid_nxt  = out_valid_r && out_stall;
    if (cmd.latch_in) begin
      char_nxt = in_char_code;
      last_nxt = in_end_of_expr;
    end
    if (cmd.digit) begin
      pend_nxt = dig_sat ? MAX_POS : num10[W-1:0];
      nip_nxt  = 1'b1;
    end
    if (cmd.flush) begin
      if (!vfull) vcnt_nxt = vcnt_r + CW'(1);
      nip_nxt  = 1'b0;
      pend_nxt = '0;
    end
    if (o_we) ocnt_nxt = ocnt_r + CW'(1);
    if (cmd.pop_op || cmd.red_pop) ocnt_nxt = otop_m1;
    if (cmd.red_pop) opcur_nxt = ord_r;
    if (cmd.red_wb) vcnt_nxt = vtop_m1;
    if (cmd.latch_b) b_nxt = vrd_r;
    if (cmd.load_out) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = aborted ? '0 : vrd_r;
      out_status_nxt = sticky_r;
    end
    if (cmd.clear) begin
      vcnt_nxt   = '0;
      ocnt_nxt   = '0;
      pend_nxt   = '0;
      nip_nxt    = 1'b0;
      sticky_nxt = iee_pkg::ST_OK;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      ocnt_r      <= '0;
      pend_r      <= '0;
      nip_r       <= 1'b0;
      sticky_r    <= iee_pkg::ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      ocnt_r      <= ocnt_nxt;
      pend_r      <= pend_nxt;
      nip_r       <= nip_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    char_r       <= char_nxt;
    last_r       <= last_nxt;
    b_r          <= b_nxt;
    opcur_r      <= opcur_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // stack memories, registered reads at the top entries
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vrd_r <= vmem[vaddr];
    if (o_we) opmem[ocnt_r[AW-1:0]] <= push_code;
    ord_r <= opmem[otop_m1[AW-1:0]];
  end

  iee_alu #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.alu_start),
    .op     (opcur_r),
    .a      (vrd_r),
    .b      (b_r),
    .done   (alu_done),
    .result (alu_res),
    .sat    (alu_sat),
    .divz   (alu_divz)
  );

  // status toward the controller
  always_comb begin
    st.cls         = iee_pkg::classify(char_r);
    st.aborted     = aborted;
    st.nip         = nip_r;
    st.last        = last_r;
    st.ocnt_zero   = (ocnt_r == '0);
    st.top_lparen  = (ord_r == iee_pkg::OP_LPAREN);
    st.top_rank_ge = iee_pkg::rank(ord_r) >= iee_pkg::rank(iee_pkg::op_of(char_r));
    st.vcnt_lt2    = vcnt_r < CW'(2);
    st.vcnt_one    = (vcnt_r == CW'(1));
    st.alu_done    = alu_done;
    st.out_busy    = out_valid_r && out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

// ----- rtl/core/infix_expression_evaluator_core.sv -----
// top level of the infix expression evaluator: controller plus datapath
// A digit goes through the character step only; any other character also takes the class step,
// unless the expression has failed, and may make operator stack passes and reductions, each
// reduction running the arithmetic unit for add/sub, multiply or divide.
// The last character adds the final reductions and the read-out (only the read-out after a
// failure), plus any wait of the output word under out_stall; one word at a time.
// Reset (synchronous, active low) clears counts, flags and output valid; stacks are not reset.
module infix_expression_evaluator_core #(
  parameter int STACK_DEPTH   = 64,
  parameter int FRACTION_BITS = 16,
  parameter int VALUE_WIDTH   = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_end_of_expr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_value,
  output logic [2:0]                    out_status
);

  iee_pkg::ctrl_cmd_t  cmd;
  iee_pkg::dp_status_t st;
  logic                in_ready;
  logic                in_fire;

  assign in_stall = !in_ready || !rst_n;
  assign in_fire  = in_valid && !in_stall;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  iee_datapath #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_char_code   (in_char_code),
    .in_end_of_expr (in_end_of_expr),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_status     (out_status)
  );

  // a word is worked on alone: no second word accepted right after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input accepted while a word is still in work");

  // aborted expressions report a zero value
  a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == iee_pkg::ST_MALFORMED || out_status == iee_pkg::ST_FULL ||
                   out_status == iee_pkg::ST_DIVZERO)) |-> (out_value == '0))
    else $error("error status with nonzero value");

endmodule

// ----- verif/testbench.sv -----
// testbench for the infix expression evaluator core: directed and random expressions
`timescale 1ns / 100ps

module testbench;

  localparam int STACK_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int VALUE_WIDTH   = 48;
  localparam int STALL_LIMIT   = 40000;
  localparam longint MAX_VAL   = (64'sd1 <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint MIN_VAL   = -MAX_VAL - 1;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    iee_pkg::status_t              status;
  } eval_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_char_code;
  logic                          in_end_of_expr;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [VALUE_WIDTH-1:0] out_value;
  logic [2:0]                    out_status;

  // evaluator state mirrored by the predictor
  longint            val_stack [STACK_DEPTH];
  iee_pkg::op_code_t opr_stack [STACK_DEPTH];
  int                val_cnt;
  int                opr_cnt;
  longint            number_acc;
  bit                in_number;
  iee_pkg::status_t  sticky;

  eval_result_t expected_results[$];
  int  mismatches;
  int  chars_sent;
  int  idle_cycles;
  bit  quiet;

  infix_expression_evaluator_core #(
    .STACK_DEPTH(STACK_DEPTH),
    .FRACTION_BITS(FRACTION_BITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .in_end_of_expr(in_end_of_expr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_status(out_status)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------- predictor ----------------

  function automatic bit halted();
    return sticky != iee_pkg::ST_OK && sticky != iee_pkg::ST_SAT;
  endfunction

  function automatic void raise(iee_pkg::status_t st);
    if (st == iee_pkg::ST_SAT) begin
      if (sticky == iee_pkg::ST_OK) sticky = iee_pkg::ST_SAT;
    end else if (sticky == iee_pkg::ST_OK || sticky == iee_pkg::ST_SAT) begin
      sticky = st;
    end
  endfunction

  function automatic void clear_eval();
    val_cnt    = 0;
    opr_cnt    = 0;
    number_acc = 0;
    in_number  = 0;
    sticky     = iee_pkg::ST_OK;
  endfunction

  function automatic longint saturate(longint v);
    if (v > MAX_VAL) begin
      raise(iee_pkg::ST_SAT);
      return MAX_VAL;
    end
    if (v < MIN_VAL) begin
      raise(iee_pkg::ST_SAT);
      return MIN_VAL;
    end
    return v;
  endfunction

  // signed result from a 128-bit magnitude, clamped to the value range
  function automatic longint signed_of(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'(MAX_VAL) + 1 : 128'(MAX_VAL);
    if (m > lim) begin
      raise(iee_pkg::ST_SAT);
      return neg ? MIN_VAL : MAX_VAL;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint arith(longint a, longint b, iee_pkg::op_code_t op);
    logic [127:0] ma;
    logic [127:0] mb;
    bit           neg;
    ma  = 128'(a < 0 ? -a : a);
    mb  = 128'(b < 0 ? -b : b);
    neg = (a < 0) != (b < 0);
    case (op)
      iee_pkg::OP_ADD: return saturate(a + b);
      iee_pkg::OP_SUB: return saturate(a - b);
      iee_pkg::OP_MUL: return signed_of(neg, (ma * mb) >> FRACTION_BITS);
      iee_pkg::OP_DIV: begin
        if (mb == 0) begin
          raise(iee_pkg::ST_DIVZERO);
          return 0;
        end
        return signed_of(neg, (ma << FRACTION_BITS) / mb);
      end
      default: begin
        raise(iee_pkg::ST_MALFORMED);
        return 0;
      end
    endcase
  endfunction

  function automatic void push_val(longint v);
    if (val_cnt >= STACK_DEPTH) raise(iee_pkg::ST_FULL);
    else begin
      val_stack[val_cnt] = v;
      val_cnt++;
    end
  endfunction

  function automatic void push_opr(iee_pkg::op_code_t op);
    if (opr_cnt >= STACK_DEPTH) raise(iee_pkg::ST_FULL);
    else begin
      opr_stack[opr_cnt] = op;
      opr_cnt++;
    end
  endfunction

  function automatic void reduce_once();
    iee_pkg::op_code_t op;
    if (opr_cnt == 0) return;
    opr_cnt--;
    op = opr_stack[opr_cnt];
    if (op == iee_pkg::OP_LPAREN || val_cnt < 2) begin
      raise(iee_pkg::ST_MALFORMED);
      return;
    end
    val_cnt--;
    val_stack[val_cnt-1] = arith(val_stack[val_cnt-1], val_stack[val_cnt], op);
  endfunction

  function automatic int prec(iee_pkg::op_code_t op);
    if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
    if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
    return 0;
  endfunction

  function automatic void end_number();
    if (in_number) push_val(number_acc);
    in_number  = 0;
    number_acc = 0;
  endfunction

  function automatic void eval_char(logic [7:0] c);
    longint            dq;
    iee_pkg::op_code_t op;
    if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
      dq = longint'(c - iee_pkg::CH_ZERO) <<< FRACTION_BITS;
      if (dq > MAX_VAL || number_acc > (MAX_VAL - dq) / 10) begin
        raise(iee_pkg::ST_SAT);
        number_acc = MAX_VAL;
      end else begin
        number_acc = number_acc * 10 + dq;
      end
      in_number = 1;
      return;
    end
    end_number();
    if (halted()) return;
    case (c)
      iee_pkg::CH_LPAREN: begin
        push_opr(iee_pkg::OP_LPAREN);
        return;
      end
      iee_pkg::CH_RPAREN: begin
        while (!halted() && opr_cnt > 0 && opr_stack[opr_cnt-1] != iee_pkg::OP_LPAREN)
          reduce_once();
        if (halted()) return;
        if (opr_cnt == 0) raise(iee_pkg::ST_MALFORMED);
        else opr_cnt--;
        return;
      end
      iee_pkg::CH_PLUS:  op = iee_pkg::OP_ADD;
      iee_pkg::CH_MINUS: op = iee_pkg::OP_SUB;
      iee_pkg::CH_STAR:  op = iee_pkg::OP_MUL;
      iee_pkg::CH_SLASH: op = iee_pkg::OP_DIV;
      default:           return;
    endcase
    while (!halted() && opr_cnt > 0 && opr_stack[opr_cnt-1] != iee_pkg::OP_LPAREN &&
           prec(opr_stack[opr_cnt-1]) >= prec(op)) reduce_once();
    if (!halted()) push_opr(op);
  endfunction

  // one accepted word; queues the result when it closes the expression
  function automatic void predict_char(logic [7:0] c, bit last);
    eval_result_t r;
    if (!halted()) eval_char(c);
    if (!last) return;
    if (!halted()) end_number();
    while (!halted() && opr_cnt > 0) reduce_once();
    if (!halted() && val_cnt != 1) raise(iee_pkg::ST_MALFORMED);
    r.value  = halted() ? '0 : VALUE_WIDTH'(val_stack[0]);
    r.status = sticky;
    expected_results.push_back(r);
    clear_eval();
  endfunction

  // ---------------- driving ----------------

  function automatic bit take_break();
    return !quiet && ($urandom_range(99) < 27);
  endfunction

  task automatic send_char(logic [7:0] c, bit last);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_expr <= last;
    do @(posedge clk); while (in_stall);
    predict_char(c, last);
    chars_sent++;
  endtask

  task automatic send_expr(string s);
    if (s.len() == 0) send_char(" ", 1'b1);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // result side: random stall and checking
  always @(posedge clk) begin
    eval_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      idle_cycles = 0;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d status %0d", out_value, out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_value !== e.value || out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                     e.value, e.status, out_value, out_status);
        end
      end
    end
    out_stall <= take_break();
  end

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- random expressions ----------------

  function automatic string rand_number();
    string s;
    int n;
    s = "";
    n = ($urandom_range(99) < 5) ? $urandom_range(15, 8) : $urandom_range(4, 1);
    for (int i = 0; i < n; i++)
      s = {s, string'(byte'(iee_pkg::CH_ZERO + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_space();
    return ($urandom_range(99) < 15) ? " " : "";
  endfunction

  function automatic string rand_expr(int depth);
    string s;
    string ops;
    int terms;
    ops   = "+-*/";
    s     = "";
    terms = $urandom_range(4, 1);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) s = {s, rand_space(), string'(ops[$urandom_range(3)]), rand_space()};
      if (depth < 3 && $urandom_range(99) < 20) s = {s, "(", rand_expr(depth + 1), ")"};
      else if ($urandom_range(99) < 8) s = {s, "0"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  function automatic string rand_noise();
    string s;
    int n;
    s = "";
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
    return s;
  endfunction

  // ---------------- tests ----------------

  task automatic test_operators();
    send_expr("1+2");
    send_expr("7 - 9*2");
    send_expr("(1+2)*3/4");
    send_expr("8/2/2");
  endtask

  task automatic test_malformed();
    send_expr("");
    send_expr(")");
    send_expr("(1");
    send_expr("1 2");
    send_expr("+");
    send_expr("5/0+1");
  endtask

  task automatic test_saturation();
    send_expr("999999999999999");
    send_expr("2147483647*4");
    send_expr("0-2147483647-9");
    send_expr("99999999999/0");
  endtask

  task automatic test_stack_full();
    string s;
    s = "";
    for (int i = 0; i < STACK_DEPTH + 1; i++) s = {s, "("};
    send_expr(s);
    s = "";
    for (int i = 0; i < STACK_DEPTH + 1; i++) s = {s, "1 "};
    send_expr(s);
  endtask

  task automatic test_drain_pause();
    send_expr("3*(4+5)");
    wait_drained();
    send_expr("6/4");
  endtask

  task automatic test_random(int target);
    string s;
    int k;
    int cut;
    while (chars_sent < target) begin
      quiet = (chars_sent > target / 2) && (chars_sent < target / 2 + 200);
      k = $urandom_range(99);
      if (k < 75) s = rand_expr(0);
      else if (k < 90) begin
        s   = rand_expr(0);
        cut = $urandom_range(s.len() - 1);
        s   = {s.substr(0, cut - 1), string'(byte'($urandom_range(255))),
               s.substr(cut + 1, s.len() - 1)};
      end else s = rand_noise();
      send_expr(s);
    end
    quiet = 0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = '0;
    in_end_of_expr = 1'b0;
    out_stall      = 1'b0;
    mismatches     = 0;
    chars_sent     = 0;
    idle_cycles    = 0;
    quiet          = 0;
    clear_eval();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_operators();
    test_malformed();
    test_saturation();
    test_stack_full();
    test_drain_pause();
    test_random(1900);

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/iee_pkg.sv
rtl/core/iee_ctrl.sv
rtl/core/iee_alu.sv
rtl/core/iee_datapath.sv
rtl/core/infix_expression_evaluator_core.sv
verif/testbench.sv
